### src/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and mode codes for the fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int WORD_W = 32;

  localparam logic [3:0] MODE_ADD      = 4'd0;
  localparam logic [3:0] MODE_SUB      = 4'd1;
  localparam logic [3:0] MODE_MUL      = 4'd2;
  localparam logic [3:0] MODE_DIV      = 4'd3;
  localparam logic [3:0] MODE_MIN      = 4'd4;
  localparam logic [3:0] MODE_MAX      = 4'd5;
  localparam logic [3:0] MODE_INC      = 4'd6;
  localparam logic [3:0] MODE_DEC      = 4'd7;
  localparam logic [3:0] MODE_TO_INT   = 4'd8;
  localparam logic [3:0] MODE_FROM_INT = 4'd9;

  // information that rides along the divider chain
  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              less;
    logic              equal;
    logic              greater;
    logic              dz;
    logic              is_div;
    logic              neg;
  } fpa_side_t;

endpackage

### src/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Two-stage front end: multiply, compare, simple modes, divide operand setup.
// ----------------------------------------------------------------------------
module fpa_front
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = 8,
  parameter int NUM_W     = WORD_W + FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [3:0]               mode,
  input  logic signed [WORD_W-1:0] operand_a,
  input  logic signed [WORD_W-1:0] operand_b,
  output logic                     valid,
  output fpa_side_t                side,
  output logic [NUM_W-1:0]         num,
  output logic [WORD_W-1:0]        divisor
);

  logic signed [2*WORD_W-1:0] prod_c;
  logic [WORD_W-1:0]          simple_c;
  logic [WORD_W-1:0]          a_mag;
  logic [WORD_W-1:0]          b_mag;
  fpa_side_t                  side_c;

  logic                       v1;
  logic                       is_mul1;
  logic [2*WORD_W-1:0]        prod1;
  fpa_side_t                  side1;
  logic [NUM_W-1:0]           num1;
  logic [WORD_W-1:0]          div1;

  always_comb begin
    prod_c = operand_a * operand_b;
    a_mag  = operand_a[WORD_W-1] ? WORD_W'(-operand_a) : WORD_W'(operand_a);
    b_mag  = operand_b[WORD_W-1] ? WORD_W'(-operand_b) : WORD_W'(operand_b);
    case (mode)
      MODE_ADD:      simple_c = WORD_W'(operand_a + operand_b);
      MODE_SUB:      simple_c = WORD_W'(operand_a - operand_b);
      MODE_MIN:      simple_c = (operand_b < operand_a) ? operand_b : operand_a;
      MODE_MAX:      simple_c = (operand_b > operand_a) ? operand_b : operand_a;
      MODE_INC:      simple_c = WORD_W'(operand_a + 32'sd1);
      MODE_DEC:      simple_c = WORD_W'(operand_a - 32'sd1);
      MODE_TO_INT:   simple_c = WORD_W'(operand_a >>> FRAC_BITS);
      MODE_FROM_INT: simple_c = WORD_W'(operand_a << FRAC_BITS);
      default:       simple_c = '0;
    endcase
  end

  always_comb begin
    side_c = side1;
    if (is_mul1) begin
      side_c.result = prod1[FRAC_BITS+WORD_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      is_mul1        <= (mode == MODE_MUL);
      prod1          <= prod_c;
      side1.result   <= simple_c;
      side1.less     <= (operand_a < operand_b);
      side1.equal    <= (operand_a == operand_b);
      side1.greater  <= (operand_a > operand_b);
      side1.is_div   <= (mode == MODE_DIV);
      side1.dz       <= (mode == MODE_DIV) && (operand_b == '0);
      side1.neg      <= operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
      num1           <= {a_mag, {FRAC_BITS{1'b0}}};
      div1           <= b_mag;

      side           <= side_c;
      num            <= num1;
      divisor        <= div1;
    end
  end

endmodule

### src/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division step: develops one quotient bit per cell.
// ----------------------------------------------------------------------------
module fpa_div_cell
  import fpa_pkg::*;
#(
  parameter int NUM_W = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [WORD_W-1:0] in_rem,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [WORD_W-1:0] in_divisor,
  input  fpa_side_t         in_side,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_rem,
  output logic [NUM_W-1:0]  out_num,
  output logic [WORD_W-1:0] out_divisor,
  output fpa_side_t         out_side
);

  logic [WORD_W:0] shifted;
  logic [WORD_W:0] diff;
  logic            ge;

  always_comb begin
    shifted = {in_rem, in_num[NUM_W-1]};
    diff    = shifted - {1'b0, in_divisor};
    ge      = (shifted >= {1'b0, in_divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem     <= ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
      out_num     <= {in_num[NUM_W-2:0], ge};
      out_divisor <= in_divisor;
      out_side    <= in_side;
    end
  end

endmodule

### src/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Quotient sign fixup, result select and output register with skid buffer.
// ----------------------------------------------------------------------------
module fpa_back
  import fpa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [WORD_W-1:0]        quot,
  input  fpa_side_t                in_side,
  output logic                     en,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] result,
  output logic                     a_less,
  output logic                     a_equal,
  output logic                     a_greater,
  output logic                     divide_by_zero
);

  fpa_side_t         word_c;
  fpa_side_t         skid;
  logic              skid_valid;
  logic              out_free;

  always_comb begin
    word_c = in_side;
    if (in_side.dz) begin
      word_c.result = '0;
    end else if (in_side.is_div) begin
      word_c.result = in_side.neg ? (~quot + WORD_W'(1)) : quot;
    end
    out_free = !out_valid || !out_stall;
    en       = !skid_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        result         <= skid.result;
        a_less         <= skid.less;
        a_equal        <= skid.equal;
        a_greater      <= skid.greater;
        divide_by_zero <= skid.dz;
      end
    end else if (in_valid) begin
      if (out_free) begin
        result         <= word_c.result;
        a_less         <= word_c.less;
        a_equal        <= word_c.equal;
        a_greater      <= word_c.greater;
        divide_by_zero <= word_c.dz;
      end else begin
        skid <= word_c;
      end
    end
  end

endmodule

### src/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU: two front stages, a chain of FRAC_BITS+32 division
// cells (one quotient bit each) that every word passes, and an output stage.
// Throughput: one word per cycle while in_stall is low; a two-entry output
// (register plus skid) lets the chain advance one more word while a result
// waits.
// Reset (rst, synchronous): clears all valid bits; no other state.
// ----------------------------------------------------------------------------
module fixed_point_alu
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [3:0]               mode,
  input  logic signed [WORD_W-1:0] operand_a,
  input  logic signed [WORD_W-1:0] operand_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] result,
  output logic                     a_less,
  output logic                     a_equal,
  output logic                     a_greater,
  output logic                     divide_by_zero
);

  localparam int NUM_W = WORD_W + FRAC_BITS;

  logic              en;
  logic              ch_valid   [0:NUM_W];
  logic [WORD_W-1:0] ch_rem     [0:NUM_W];
  logic [NUM_W-1:0]  ch_num     [0:NUM_W];
  logic [WORD_W-1:0] ch_divisor [0:NUM_W];
  fpa_side_t         ch_side    [0:NUM_W];

  assign in_stall  = !en;
  assign ch_rem[0] = '0;

  fpa_front #(
    .FRAC_BITS (FRAC_BITS),
    .NUM_W     (NUM_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .mode      (mode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .valid     (ch_valid[0]),
    .side      (ch_side[0]),
    .num       (ch_num[0]),
    .divisor   (ch_divisor[0])
  );

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    fpa_div_cell #(
      .NUM_W (NUM_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .en          (en),
      .in_valid    (ch_valid[i]),
      .in_rem      (ch_rem[i]),
      .in_num      (ch_num[i]),
      .in_divisor  (ch_divisor[i]),
      .in_side     (ch_side[i]),
      .out_valid   (ch_valid[i+1]),
      .out_rem     (ch_rem[i+1]),
      .out_num     (ch_num[i+1]),
      .out_divisor (ch_divisor[i+1]),
      .out_side    (ch_side[i+1])
    );
  end

  fpa_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (ch_valid[NUM_W]),
    .quot           (ch_num[NUM_W][WORD_W-1:0]),
    .in_side        (ch_side[NUM_W]),
    .en             (en),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result         (result),
    .a_less         (a_less),
    .a_equal        (a_equal),
    .a_greater      (a_greater),
    .divide_by_zero (divide_by_zero)
  );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fixed_point_alu. Directed cases, then random bursts,
// are sent while the result side stalls on its own pattern, including one long
// hold that backs the pipeline up. Every accepted word is predicted on entry
// and each result word is checked in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import fpa_pkg::*;

  localparam int FRAC_BITS  = 8;
  localparam int LATENCY    = FRAC_BITS + 35;
  localparam int RANDOM_OPS = 1700;
  localparam int LONG_HOLD  = 300;

  localparam logic [3:0] MODE_UNUSED_LO = 4'd10;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

  localparam logic signed [WORD_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [WORD_W-1:0] result;
    logic                     less;
    logic                     equal;
    logic                     greater;
    logic                     dz;
  } alu_word_t;

  class fixed_point_scoreboard;
    alu_word_t   expected_words[$];
    int unsigned failures = 0;

    function void add_operation(input logic [3:0] op,
                                input logic signed [WORD_W-1:0] a,
                                input logic signed [WORD_W-1:0] b);
      alu_word_t          w;
      logic signed [63:0] wide_a;
      logic signed [63:0] wide_b;
      logic signed [63:0] wide_res;
      wide_a = a;
      wide_b = b;
      w = '0;
      case (op)
        MODE_ADD: w.result = a + b;
        MODE_SUB: w.result = a - b;
        MODE_MUL: begin
          wide_res = (wide_a * wide_b) >>> FRAC_BITS;
          w.result = wide_res[WORD_W-1:0];
        end
        MODE_DIV: begin
          if (b == 0) begin
            w.dz = 1'b1;
          end else begin
            wide_res = (wide_a <<< FRAC_BITS) / wide_b;
            w.result = wide_res[WORD_W-1:0];
          end
        end
        MODE_MIN:      w.result = (b < a) ? b : a;
        MODE_MAX:      w.result = (b > a) ? b : a;
        MODE_INC:      w.result = a + 32'sd1;
        MODE_DEC:      w.result = a - 32'sd1;
        MODE_TO_INT:   w.result = a >>> FRAC_BITS;
        MODE_FROM_INT: w.result = a << FRAC_BITS;
        default:       w.result = '0;
      endcase
      w.less    = a < b;
      w.equal   = a == b;
      w.greater = a > b;
      expected_words.push_back(w);
    endfunction

    function void compare_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(input alu_word_t got);
      alu_word_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %h", $time, got);
        failures++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("result", want.result, got.result);
      compare_field("a_less", want.less, got.less);
      compare_field("a_equal", want.equal, got.equal);
      compare_field("a_greater", want.greater, got.greater);
      compare_field("divide_by_zero", want.dz, got.dz);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [3:0]               mode = MODE_ADD;
  logic signed [WORD_W-1:0] operand_a = '0;
  logic signed [WORD_W-1:0] operand_b = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [WORD_W-1:0] result;
  logic                     a_less;
  logic                     a_equal;
  logic                     a_greater;
  logic                     divide_by_zero;

  int unsigned ops_accepted = 0;
  fixed_point_scoreboard sb = new();

  fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) uut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.add_operation(mode, operand_a, operand_b);
        ops_accepted <= ops_accepted + 1;
      end
      if (out_valid && !out_stall)
        sb.check_result({result, a_less, a_equal, a_greater, divide_by_zero});
    end
  end

  // result side: stall segments of varying density, plus one long hold once
  // traffic is flowing so the pipeline fills and pushes back on the input
  initial begin : receiver
    int  seg_len;
    int  style;
    int  held;
    bit  hold_done;
    hold_done = 1'b0;
    forever begin
      if (!hold_done && ops_accepted >= 700) begin
        for (held = 0; held < LONG_HOLD; held++) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
        hold_done = 1'b1;
      end else begin
        style   = $urandom_range(0, 3);
        seg_len = $urandom_range(10, 150);
        repeat (seg_len) begin
          @(posedge clk);
          case (style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 9) < 3);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  // called right after a rising edge; returns at the edge that accepts the word
  task automatic send_operation(input logic [3:0] op,
                                input logic signed [WORD_W-1:0] a,
                                input logic signed [WORD_W-1:0] b);
    in_valid  <= 1'b1;
    mode      <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    pause_input(1);
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 2048)) - 32'sd1024;
      7: begin
        case ($urandom_range(0, 3))
          0:       return MOST_NEG;
          1:       return MOST_POS;
          2:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      8:       return $signed($urandom_range(0, 255) - 128) <<< FRAC_BITS;
      default: return '0;
    endcase
  endfunction

  function automatic logic [3:0] pick_mode();
    if ($urandom_range(0, 19) == 0)
      return 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    return 4'($urandom_range(MODE_ADD, MODE_FROM_INT));
  endfunction

  initial begin : stimulus
    int                       sent;
    int                       burst;
    bit                       paused;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    sent   = 0;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_operation(MODE_ADD, MOST_POS, 32'sd1);
    send_operation(MODE_SUB, MOST_NEG, 32'sd1);
    send_operation(MODE_MUL, MOST_POS, MOST_POS);
    send_operation(MODE_MUL, MOST_NEG, MOST_NEG);
    send_operation(MODE_MUL, -32'sd1, 32'sd1);
    send_operation(MODE_MUL, 32'sh0001_0000, 32'sh0001_0000);
    pause_input(3);
    send_operation(MODE_DIV, 32'sd256, 32'sd0);
    send_operation(MODE_DIV, 32'sd0, 32'sd0);
    send_operation(MODE_DIV, MOST_NEG, -32'sd1);
    send_operation(MODE_DIV, MOST_POS, 32'sd1);
    send_operation(MODE_DIV, -32'sd1, 32'sd512);
    send_operation(MODE_MIN, 32'sd5, 32'sd5);
    send_operation(MODE_MAX, -32'sd7, -32'sd7);
    send_operation(MODE_MIN, MOST_NEG, MOST_POS);
    send_operation(MODE_MAX, MOST_NEG, MOST_POS);
    pause_input(1);
    send_operation(MODE_INC, MOST_POS, 32'sd0);
    send_operation(MODE_DEC, MOST_NEG, 32'sd0);
    send_operation(MODE_TO_INT, -32'sd1, 32'sd3);
    send_operation(MODE_TO_INT, MOST_NEG, MOST_NEG);
    send_operation(MODE_FROM_INT, MOST_POS, -32'sd1);
    send_operation(MODE_FROM_INT, -32'sd1, MOST_POS);
    send_operation(MODE_UNUSED_LO, 32'sd9, 32'sd4);
    send_operation(MODE_UNUSED_HI, MOST_NEG, MOST_POS);
    send_operation(MODE_ADD, 32'sd0, 32'sd0);
    wait_for_drain();

    while (sent < RANDOM_OPS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        a = pick_operand();
        case ($urandom_range(0, 9))
          0, 1:    b = a;
          2:       b = '0;
          default: b = pick_operand();
        endcase
        send_operation(pick_mode(), a, b);
        sent++;
      end
      if (!paused && sent >= 1200) begin
        wait_for_drain();
        paused = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        pause_input($urandom_range(1, 12));
      end
    end

    wait_for_drain();
    if (sb.failures == 0 && sb.expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(12 * 400000);
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
src/fpa_pkg.sv
src/fpa_front.sv
src/fpa_div_cell.sv
src/fpa_back.sv
src/fixed_point_alu.sv
tb/testbench.sv
